### design/basic_token_scanner_assert.svh
// assertion macros for the token scanner
// used by the top level only, no other dependencies
`ifndef BASIC_TOKEN_SCANNER_ASSERT_SVH
`define BASIC_TOKEN_SCANNER_ASSERT_SVH
`define BTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/bts_pkg.sv
// shared types and constants for the token scanner
// no dependencies
`default_nettype none
package bts_pkg;
  localparam int unsigned POS_W = 22;
  localparam int unsigned LC_W  = 23;
  localparam int unsigned TEXT_LIMIT_DEFAULT = 4194304;

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_STRING  = 5'd7;
  localparam logic [4:0] KIND_NEWLINE = 5'd8;
  localparam logic [4:0] KIND_ASSIGN  = 5'd9;
  localparam logic [4:0] KIND_EQUAL   = 5'd10;
  localparam logic [4:0] KIND_LESS    = 5'd11;
  localparam logic [4:0] KIND_GREATER = 5'd12;
  localparam logic [4:0] KIND_LE      = 5'd13;
  localparam logic [4:0] KIND_GE      = 5'd14;
  localparam logic [4:0] KIND_ADD     = 5'd15;
  localparam logic [4:0] KIND_SUB     = 5'd16;
  localparam logic [4:0] KIND_NUM_EOF = 5'd17;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CHAR    = 3'd1;
  localparam logic [2:0] ERR_NUMBER  = 3'd2;
  localparam logic [2:0] ERR_STRING  = 3'd3;
  localparam logic [2:0] ERR_COMPARE = 3'd4;

  // one result item
  typedef struct packed {
    logic [4:0]      token_kind;
    logic            is_eof;
    logic [2:0]      fault_code;
    logic [POS_W-1:0] text_offset;
    logic [POS_W-1:0] text_length;
    logic [LC_W-1:0]  line_number;
    logic [LC_W-1:0]  column_number;
    logic            last_of_run;
  } token_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
    logic       alpha;
    logic       digit;
    logic       space;
    logic       str_bad;
  } cls_t;

  localparam int unsigned TOKEN_W = $bits(token_t);
  localparam int unsigned CLS_W   = $bits(cls_t);

  // exact keyword match on the last eight letters and the saturated count
  function automatic logic [4:0] kw_kind(input logic [63:0] w, input logic [3:0] n);
    logic [4:0] k;
    k = KIND_IDENT;
    if (n == 4'd5 && w[39:0] == "WHILE") k = 5'd1;
    if (n == 4'd8 && w == "ENDWHILE") k = 5'd2;
    if (n == 4'd3 && w[23:0] == "LET") k = 5'd3;
    if (n == 4'd5 && w[39:0] == "PRINT") k = 5'd4;
    if (n == 4'd5 && w[39:0] == "INPUT") k = 5'd5;
    if (n == 4'd6 && w[47:0] == "REPEAT") k = 5'd6;
    return k;
  endfunction
endpackage
`default_nettype wire

### design/bts_fifo.sv
// small first-word-fall-through queue between scanner stages
// depends on nothing
`default_nettype none
module bts_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH_LOG2 = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wp_r, rp_r;
  logic [DEPTH_LOG2:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != DEPTH[DEPTH_LOG2:0]);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

### design/bts_front.sv
// front stage: accepts bytes and classifies them
// depends on bts_pkg
`default_nettype none
module bts_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_eot,
  output logic             cls_valid,
  input  wire logic        cls_ready,
  output bts_pkg::cls_t    cls_data
);
  import bts_pkg::*;
  cls_t c;
  logic [7:0] b;
  always_comb begin
    b = in_byte;
    c.eot = in_eot || (b == 8'd0);
    c.ch = b;
    c.alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    c.digit = (b >= "0" && b <= "9");
    c.space = (b == " ") || (b == 8'd9) || (b == 8'd11) || (b == 8'd12) || (b == 8'd13);
    c.str_bad = (b == "\\") || (b == "%") || (b == 8'd13) || (b == 8'd10) || (b == 8'd9);
  end
  bts_fifo #(.WIDTH(CLS_W), .DEPTH_LOG2(1)) u_q (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(c),
    .rd_valid(cls_valid), .rd_ready(cls_ready), .rd_data(cls_data)
  );
endmodule
`default_nettype wire

### design/bts_back.sv
// back stage: scanner state and token emission, two-entry output queue
// depends on bts_pkg and bts_fifo
`default_nettype none
module bts_back #(
  parameter int unsigned TEXT_LIMIT = bts_pkg::TEXT_LIMIT_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cls_valid,
  output logic               cls_ready,
  input  wire bts_pkg::cls_t cls_data,
  output logic               tok_valid,
  input  wire logic          tok_ready,
  output bts_pkg::token_t    tok_data,
  output logic               halted_o
);
  import bts_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_WORD, S_STRING, S_INT, S_POINT, S_FRAC, S_COMMENT, S_EQ, S_LT, S_GT
  } mode_t;
  localparam logic [POS_W-1:0] LC_MAX = {POS_W{1'b1}};
  localparam logic [POS_W:0] LIM = (POS_W+1)'(TEXT_LIMIT);

  mode_t mode_r, mode_nxt;
  logic [POS_W-1:0] start_r, pos_r, line_r, col_r, sline_r, scol_r;
  logic [POS_W-1:0] start_nxt, pos_nxt, line_nxt, col_nxt, sline_nxt, scol_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0] wcnt_r, wcnt_nxt;
  logic halted_r, halted_nxt;
  token_t t0, t1, s_data;
  logic [1:0] nres;
  logic go;
  logic pend_r;
  token_t pend_tok_r;
  logic q_ready, q_wvalid;
  logic [POS_W-1:0] sp;
  logic [POS_W:0] pinc;

  // results go one per cycle into the queue while it has room; a second result waits in pend
  assign cls_ready = !pend_r && q_ready;
  assign go = cls_valid && cls_ready;
  assign halted_o = halted_r;
  // token span modulo the text limit
  assign sp = (pos_r >= start_r) ? pos_r - start_r
                                 : POS_W'({1'b0, pos_r} + LIM - {1'b0, start_r});

  function automatic token_t mk(input logic [4:0] k, input logic e, input logic [2:0] er,
                                input logic [POS_W-1:0] o, input logic [POS_W-1:0] l,
                                input logic [POS_W-1:0] ln, input logic [POS_W-1:0] cl);
    token_t t;
    t.token_kind = k; t.is_eof = e; t.fault_code = er; t.text_offset = o;
    t.text_length = l; t.line_number = {1'b0, ln}; t.column_number = {1'b0, cl};
    t.last_of_run = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic consumed;
    logic [7:0] c;
    logic [4:0] single;
    token_t r;
    mode_nxt = mode_r; start_nxt = start_r; pos_nxt = pos_r; line_nxt = line_r;
    col_nxt = col_r; sline_nxt = sline_r; scol_nxt = scol_r; word_nxt = word_r;
    wcnt_nxt = wcnt_r; halted_nxt = halted_r;
    nres = 2'd0; t0 = '0; t1 = '0; consumed = 1'b0; c = cls_data.ch; r = '0;
    single = KIND_ASSIGN;
    pinc = {1'b0, pos_r} + 1'b1;
    if (cls_data.eot) begin
      unique case (mode_r)
        S_WORD: begin r = mk(kw_kind(word_r, wcnt_r), 0, ERR_NONE, start_r, sp, sline_r, scol_r); nres = 1; end
        S_INT, S_FRAC: begin r = mk(KIND_NUM_EOF, 0, ERR_NONE, start_r, sp, sline_r, scol_r); nres = 1; end
        S_STRING: begin
          r = mk(KIND_STRING, 0, ERR_NONE, POS_W'((({1'b0, start_r} + 1'b1) == LIM) ? '0 : start_r + 1'b1),
                 (sp == '0) ? '0 : sp - 1'b1, sline_r, scol_r);
          nres = 1;
        end
        S_POINT: begin r = mk(KIND_IDENT, 0, ERR_NUMBER, pos_r, '0, line_r, col_r); nres = 1; halted_nxt = 1; end
        S_EQ, S_LT, S_GT: begin r = mk(KIND_IDENT, 0, ERR_COMPARE, start_r, '0, sline_r, scol_r); nres = 1; halted_nxt = 1; end
        default: ;
      endcase
      t0 = r;
      if (!halted_nxt) begin
        if (nres == 2'd1) t1 = mk(KIND_NUM_EOF, 1, ERR_NONE, pos_r, '0, line_r, col_r);
        else t0 = mk(KIND_NUM_EOF, 1, ERR_NONE, pos_r, '0, line_r, col_r);
        nres = nres + 1'b1;
        mode_nxt = S_IDLE; start_nxt = '0; pos_nxt = '0; line_nxt = 1; col_nxt = 1;
        sline_nxt = 1; scol_nxt = 1; word_nxt = '0; wcnt_nxt = '0;
      end
    end else begin
      unique case (mode_r)
        S_WORD: if (cls_data.alpha) begin
          word_nxt = {word_r[55:0], c};
          if (wcnt_r < 4'd9) wcnt_nxt = wcnt_r + 1'b1;
          consumed = 1;
        end else begin
          r = mk(kw_kind(word_r, wcnt_r), 0, ERR_NONE, start_r, sp, sline_r, scol_r); nres = 1;
          mode_nxt = S_IDLE;
        end
        S_STRING: begin
          consumed = 1;
          if (c == "\"") begin
            r = mk(KIND_STRING, 0, ERR_NONE, POS_W'((({1'b0, start_r} + 1'b1) == LIM) ? '0 : start_r + 1'b1),
                   (sp == '0) ? '0 : sp - 1'b1, sline_r, scol_r);
            nres = 1; mode_nxt = S_IDLE;
          end else if (cls_data.str_bad) begin
            r = mk(KIND_IDENT, 0, ERR_STRING, pos_r, '0, line_r, col_r); nres = 1; halted_nxt = 1;
          end
        end
        S_INT, S_FRAC: if (cls_data.digit) consumed = 1;
          else if (c == ".") begin
            consumed = 1;
            if (mode_r == S_FRAC) begin
              r = mk(KIND_IDENT, 0, ERR_NUMBER, pos_r, '0, line_r, col_r); nres = 1; halted_nxt = 1;
            end else mode_nxt = S_POINT;
          end else begin
            r = mk(KIND_NUM_EOF, 0, ERR_NONE, start_r, sp, sline_r, scol_r); nres = 1;
            mode_nxt = S_IDLE;
          end
        S_POINT: begin
          consumed = 1;
          if (cls_data.digit) mode_nxt = S_FRAC;
          else begin r = mk(KIND_IDENT, 0, ERR_NUMBER, pos_r, '0, line_r, col_r); nres = 1; halted_nxt = 1; end
        end
        S_COMMENT: if (c == 8'd10) mode_nxt = S_IDLE; else consumed = 1;
        S_EQ, S_LT, S_GT: begin
          single = (mode_r == S_EQ) ? KIND_ASSIGN : (mode_r == S_LT) ? KIND_LESS : KIND_GREATER;
          if (c == "=") begin
            r = mk((mode_r == S_EQ) ? KIND_EQUAL : (mode_r == S_LT) ? KIND_LE : KIND_GE,
                   0, ERR_NONE, start_r, 2, sline_r, scol_r);
            consumed = 1;
          end else r = mk(single, 0, ERR_NONE, start_r, 1, sline_r, scol_r);
          nres = 1; mode_nxt = S_IDLE;
        end
        default: mode_nxt = S_IDLE;
      endcase
      t0 = r;
      if (!halted_nxt && !consumed) begin
        r = '0;
        if (cls_data.alpha) begin
          mode_nxt = S_WORD; word_nxt = {56'd0, c}; wcnt_nxt = 4'd1;
        end else if (c == "\"") mode_nxt = S_STRING;
        else if (c == 8'd10) r = mk(KIND_NEWLINE, 0, ERR_NONE, pos_r, 1, line_r, col_r);
        else if (cls_data.space) ;
        else if (c == "=") mode_nxt = S_EQ;
        else if (c == "<") mode_nxt = S_LT;
        else if (c == ">") mode_nxt = S_GT;
        else if (c == "+") r = mk(KIND_ADD, 0, ERR_NONE, pos_r, 1, line_r, col_r);
        else if (c == "-") r = mk(KIND_SUB, 0, ERR_NONE, pos_r, 1, line_r, col_r);
        else if (cls_data.digit) mode_nxt = S_INT;
        else if (c == "#") mode_nxt = S_COMMENT;
        else begin r = mk(KIND_IDENT, 0, ERR_CHAR, pos_r, '0, line_r, col_r); halted_nxt = 1; end
        if (cls_data.alpha || c == "\"" || c == "=" || c == "<" || c == ">" || cls_data.digit) begin
          start_nxt = pos_r; sline_nxt = line_r; scol_nxt = col_r;
        end
        if (r.text_length != '0 || r.fault_code != ERR_NONE) begin
          if (nres == 2'd0) t0 = r; else t1 = r;
          nres = nres + 1'b1;
        end
      end
      if (!halted_nxt) begin
        pos_nxt = (pinc == LIM) ? '0 : pinc[POS_W-1:0];
        if (c == 8'd10) begin
          if (line_r < LC_MAX) line_nxt = line_r + 1'b1;
          col_nxt = 1;
        end else if (col_r < LC_MAX) col_nxt = col_r + 1'b1;
      end
    end
    if (nres == 2'd1) t0.last_of_run = 1'b1;
    if (nres == 2'd2) t1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= S_IDLE; start_r <= '0; pos_r <= '0; line_r <= 1; col_r <= 1;
      sline_r <= 1; scol_r <= 1; word_r <= '0; wcnt_r <= '0; halted_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (go && !halted_r) begin
        mode_r <= mode_nxt; start_r <= start_nxt; pos_r <= pos_nxt; line_r <= line_nxt;
        col_r <= col_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt; word_r <= word_nxt;
        wcnt_r <= wcnt_nxt; halted_r <= halted_nxt;
        pend_r <= (nres == 2'd2);
      end else if (pend_r && q_ready) pend_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (go && nres == 2'd2) pend_tok_r <= t1;
  end

  assign q_wvalid = pend_r || (go && !halted_r && nres != 2'd0);
  assign s_data = pend_r ? pend_tok_r : t0;

  bts_fifo #(.WIDTH(TOKEN_W), .DEPTH_LOG2(1)) u_out (
    .clk, .rst_n,
    .wr_valid(q_wvalid), .wr_ready(q_ready), .wr_data(s_data),
    .rd_valid(tok_valid), .rd_ready(tok_ready), .rd_data(tok_data)
  );
endmodule
`default_nettype wire

### design/basic_token_scanner.sv
// path: a taken byte is registered in the input queue; the back stage turns it into
// tokens combinationally, and they are registered in the output queue
// throughput: one byte per cycle while the output queue has room; a byte that yields
// two tokens holds the input while the second token enters the output queue
// reset: synchronous active-low rst_n clears scanner state, queues and the halt flag
`default_nettype none
module basic_token_scanner #(
  parameter int unsigned TEXT_LIMIT = bts_pkg::TEXT_LIMIT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // fault_code, text_offset, text_length,
                                       // line_number, column_number, pad
  output logic [7:0]       out_tuser,  // token_kind, is_eof, pad
  output logic             out_tlast   // last_of_run
);
  import bts_pkg::*;
  `include "basic_token_scanner_assert.svh"

  logic cls_valid, cls_ready, halted;
  cls_t cls_data;
  token_t tok;

  // front classifies bytes into a two-entry queue
  bts_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_byte(in_tdata), .in_eot(in_tlast),
    .cls_valid, .cls_ready, .cls_data
  );

  // back runs the scanner and feeds the output queue
  bts_back #(.TEXT_LIMIT(TEXT_LIMIT)) u_back (
    .clk, .rst_n, .cls_valid, .cls_ready, .cls_data,
    .tok_valid(out_tvalid), .tok_ready(out_tready), .tok_data(tok),
    .halted_o(halted)
  );

  assign out_tdata = {3'd0, tok.column_number, tok.line_number, tok.text_length,
                      tok.text_offset, tok.fault_code};
  assign out_tuser = {2'd0, tok.is_eof, tok.token_kind};
  assign out_tlast = tok.last_of_run;

  `BTS_ASSERT_IMPL(a_eof_last, out_tvalid && tok.is_eof, tok.last_of_run,
                   "eof token not last of run")
  `BTS_ASSERT_IMPL(a_err_len, out_tvalid && tok.fault_code != ERR_NONE,
                   tok.text_length == '0 && !tok.is_eof, "error token malformed")
  `BTS_ASSERT_NEXT(a_halt_sticky, halted, halted, "halt flag dropped without reset")
endmodule
`default_nettype wire

### bench/token_checker.sv
// token stream checker for basic_token_scanner: predicts the tokens of each
// accepted text byte and compares them with the result stream
// depends on bts_pkg for the result layout and the kind and error codes
`timescale 1ns / 1ps
module token_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [95:0]  out_tdata,
  input  wire logic [7:0]   out_tuser,
  input  wire logic         out_tlast,
  output int                fail_count,
  output int                outstanding
);
  import bts_pkg::*;

  typedef enum logic [3:0] {
    SC_IDLE, SC_WORD, SC_STRING, SC_INT, SC_POINT, SC_FRAC, SC_COMMENT,
    SC_EQ, SC_LT, SC_GT
  } scan_state_e;

  localparam logic [21:0] COUNT_MAX = 22'h3FFFFF;

  scan_state_e  mode;
  logic [21:0]  tok_start, pos, line, col, s_line, s_col;
  logic [63:0]  letters;
  logic [3:0]   n_letters;
  bit           halted;
  token_t       expected_tokens[$];

  function automatic logic [4:0] keyword_of(logic [63:0] w, logic [3:0] n);
    string       words[6];
    logic [63:0] packed_word;
    words = '{"WHILE", "ENDWHILE", "LET", "PRINT", "INPUT", "REPEAT"};
    for (int k = 0; k < 6; k++) begin
      packed_word = '0;
      for (int i = 0; i < words[k].len(); i++) packed_word = (packed_word << 8) | words[k][i];
      if (n == words[k].len() && w == packed_word) return 5'(k + 1);
    end
    return KIND_IDENT;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_scan();
    mode = SC_IDLE;
    tok_start = '0;
    pos = '0;
    line = 22'd1;
    col = 22'd1;
    s_line = 22'd1;
    s_col = 22'd1;
    letters = '0;
    n_letters = '0;
    halted = 0;
  endtask

  task automatic add_token(logic [4:0] kind, bit eof, logic [2:0] err, logic [21:0] off,
                           logic [21:0] len, logic [21:0] ln, logic [21:0] cl);
    token_t t;
    t.token_kind = kind;
    t.is_eof = eof;
    t.fault_code = err;
    t.text_offset = off;
    t.text_length = len;
    t.line_number = {1'b0, ln};
    t.column_number = {1'b0, cl};
    t.last_of_run = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic add_span(logic [4:0] kind);
    add_token(kind, 0, ERR_NONE, tok_start, pos - tok_start, s_line, s_col);
  endtask

  // string text leaves out the opening quote
  task automatic add_string();
    logic [21:0] len;
    len = pos - tok_start;
    add_token(KIND_STRING, 0, ERR_NONE, tok_start + 22'd1, (len == 0) ? 22'd0 : len - 22'd1,
              s_line, s_col);
  endtask

  task automatic add_error(logic [2:0] err);
    add_token(KIND_IDENT, 0, err, pos, 0, line, col);
    halted = 1;
  endtask

  task automatic begin_token(scan_state_e m);
    mode = m;
    tok_start = pos;
    s_line = line;
    s_col = col;
  endtask

  task automatic idle_char(logic [7:0] c);
    if (is_letter(c)) begin
      begin_token(SC_WORD);
      letters = {56'd0, c};
      n_letters = 4'd1;
    end else if (c == "\"") begin_token(SC_STRING);
    else if (c == "\n") add_token(KIND_NEWLINE, 0, ERR_NONE, pos, 1, line, col);
    else if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D) begin
      // whitespace is skipped
    end else if (c == "=") begin_token(SC_EQ);
    else if (c == "<") begin_token(SC_LT);
    else if (c == ">") begin_token(SC_GT);
    else if (c == "+") add_token(KIND_ADD, 0, ERR_NONE, pos, 1, line, col);
    else if (c == "-") add_token(KIND_SUB, 0, ERR_NONE, pos, 1, line, col);
    else if (is_digit(c)) begin_token(SC_INT);
    else if (c == "#") mode = SC_COMMENT;
    else add_error(ERR_CHAR);
  endtask

  task automatic scan_byte(logic [7:0] c, logic eot);
    int   n_before;
    bit   consumed;
    logic [4:0] single;
    n_before = expected_tokens.size();
    consumed = 0;
    if (halted) return;
    if (eot || c == 8'd0) begin
      case (mode)
        SC_WORD:          add_span(keyword_of(letters, n_letters));
        SC_INT, SC_FRAC:  add_span(KIND_NUM_EOF);
        SC_STRING:        add_string();
        SC_POINT:         add_error(ERR_NUMBER);
        SC_EQ, SC_LT, SC_GT: begin
          add_token(KIND_IDENT, 0, ERR_COMPARE, tok_start, 0, s_line, s_col);
          halted = 1;
        end
        default: ;
      endcase
      if (!halted) begin
        add_token(KIND_NUM_EOF, 1, ERR_NONE, pos, 0, line, col);
        clear_scan();
      end
    end else begin
      case (mode)
        SC_WORD: begin
          if (is_letter(c)) begin
            letters = (letters << 8) | c;
            if (n_letters < 4'd9) n_letters++;
            consumed = 1;
          end else begin
            add_span(keyword_of(letters, n_letters));
            mode = SC_IDLE;
          end
        end
        SC_STRING: begin
          consumed = 1;
          if (c == "\"") begin
            add_string();
            mode = SC_IDLE;
          end else if (c == "\\" || c == "%" || c == 8'h0D || c == "\n" || c == 8'h09) begin
            add_error(ERR_STRING);
          end
        end
        SC_INT, SC_FRAC: begin
          if (is_digit(c)) consumed = 1;
          else if (c == ".") begin
            consumed = 1;
            if (mode == SC_FRAC) add_error(ERR_NUMBER);
            else mode = SC_POINT;
          end else begin
            add_span(KIND_NUM_EOF);
            mode = SC_IDLE;
          end
        end
        SC_POINT: begin
          consumed = 1;
          if (is_digit(c)) mode = SC_FRAC;
          else add_error(ERR_NUMBER);
        end
        SC_COMMENT: begin
          if (c == "\n") mode = SC_IDLE;
          else consumed = 1;
        end
        SC_EQ, SC_LT, SC_GT: begin
          single = (mode == SC_EQ) ? KIND_ASSIGN : (mode == SC_LT) ? KIND_LESS : KIND_GREATER;
          if (c == "=") begin
            add_token((mode == SC_EQ) ? KIND_EQUAL : (mode == SC_LT) ? KIND_LE : KIND_GE,
                      0, ERR_NONE, tok_start, 2, s_line, s_col);
            consumed = 1;
          end else begin
            add_token(single, 0, ERR_NONE, tok_start, 1, s_line, s_col);
          end
          mode = SC_IDLE;
        end
        default: mode = SC_IDLE;
      endcase
      if (!halted && !consumed) idle_char(c);
      if (!halted) begin
        pos = pos + 22'd1;
        if (c == "\n") begin
          if (line < COUNT_MAX) line++;
          col = 22'd1;
        end else if (col < COUNT_MAX) begin
          col++;
        end
      end
    end
    if (expected_tokens.size() > n_before)
      expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
    clear_scan();
  end

  always @(posedge clk) begin
    token_t e;
    if (!rst_n) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("token_kind", e.token_kind, out_tuser[4:0]);
          check_field("is_eof", e.is_eof, out_tuser[5]);
          check_field("fault_code", e.fault_code, out_tdata[2:0]);
          check_field("text_offset", e.text_offset, out_tdata[24:3]);
          check_field("text_length", e.text_length, out_tdata[46:25]);
          check_field("line_number", e.line_number, out_tdata[69:47]);
          check_field("column_number", e.column_number, out_tdata[92:70]);
          check_field("last_of_run", e.last_of_run, out_tlast);
        end
      end
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
    outstanding = expected_tokens.size();
  end
endmodule

### bench/testbench.sv
// top of the basic_token_scanner bench: drives source text and the result
// ready, instantiates the scanner and token_checker and gives the verdict
// depends on bts_pkg, basic_token_scanner and token_checker
`timescale 1ns / 1ps
module testbench;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [7:0]   out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           outstanding;

  // pacing knobs, percent of cycles spent idle or stalled
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int bytes_sent;

  basic_token_scanner i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  token_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast), .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // overall time limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("basic_token_scanner: mismatch");
    $finish;
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready = 0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one request on the text side, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] c, logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = c;
    in_tlast = eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 0;
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  task automatic send_end();
    if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1);
    else send_byte(8'd0, 0);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return $urandom_range(1) ? "A" + c : "a" + c;
  endfunction

  // any byte that does not end or break a string
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == "\"" || c == "\\" || c == "%" || c == 8'h0D || c == "\n" || c == 8'h09);
    return c;
  endfunction

  // one well-formed lexeme followed by a separator, or an end of text
  task automatic send_lexeme();
    string kws[6];
    string ops[8];
    kws = '{"WHILE", "ENDWHILE", "LET", "PRINT", "INPUT", "REPEAT"};
    ops = '{"=", "==", "<", "<=", ">", ">=", "+", "-"};
    case ($urandom_range(11))
      0, 1: send_text(kws[$urandom_range(5)]);
      2: begin
        // near misses of keywords
        send_text(kws[$urandom_range(5)]);
        send_byte(rand_letter(), 0);
      end
      3, 4: repeat ($urandom_range(1, 11)) send_byte(rand_letter(), 0);
      5, 6: begin
        repeat ($urandom_range(1, 4)) send_byte(8'("0" + $urandom_range(9)), 0);
        if ($urandom_range(1)) begin
          send_byte(".", 0);
          repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(9)), 0);
        end
      end
      7: begin
        send_byte("\"", 0);
        repeat ($urandom_range(0, 6)) send_byte(string_char(), 0);
        send_byte("\"", 0);
      end
      8: send_byte("\n", 0);
      9: send_text(ops[$urandom_range(7)]);
      10: begin
        send_byte("#", 0);
        repeat ($urandom_range(0, 6)) begin
          logic [7:0] c;
          do c = 8'($urandom_range(1, 255)); while (c == "\n");
          send_byte(c, 0);
        end
        if ($urandom_range(3) == 0) begin
          send_end();
          return;
        end
        send_byte("\n", 0);
      end
      default: begin
        if ($urandom_range(3) == 0) begin
          // unterminated string closed by the end of text
          send_byte("\"", 0);
          repeat ($urandom_range(0, 4)) send_byte(string_char(), 0);
        end
        send_end();
        return;
      end
    endcase
    case ($urandom_range(4))
      0: send_byte(8'h09, 0);
      1: send_byte(8'h0B, 0);
      2: send_byte(8'h0C, 0);
      3: send_byte(8'h0D, 0);
      default: send_byte(" ", 0);
    endcase
  endtask

  initial begin
    bit held;
    bit paused;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    bytes_sent = 0;
    held = 0;
    paused = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: keywords, near misses, operators, numbers, strings, comment
    send_text("LET ab=1.5<=x>=y\n\"a b\"==2<3>4+-");
    send_text("PRINTX REPEA #c\n");
    send_byte(8'hFF, 1);
    send_text("1.");

    send_text("0 \"");
    send_byte(8'd0, 0);

    // random lexemes across the pacing phases
    while (bytes_sent < 800) begin
      case (bytes_sent / 200)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      if (!held && bytes_sent > 300) begin
        // long result hold-off while text keeps coming, fills the scanner
        held = 1;
        hold_req = 1;
      end
      if (!paused && bytes_sent > 550) begin
        // text pause until every token is out
        paused = 1;
        while (outstanding != 0) @(negedge clk);
      end
      send_lexeme();
    end
    send_end();

    // one error case at the end, since an error halts the scanner for good
    case ($urandom_range(5))
      0: send_byte(($urandom_range(1)) ? "@" : 8'h80 | 8'($urandom_range(127)), 0);
      1: send_text("7.2.");
      2: send_text("3.x");
      3: begin send_text("9."); send_end(); end
      4: begin send_byte("\"", 0); send_byte(($urandom_range(1)) ? "\\" : "%", 0); end
      default: begin send_text(($urandom_range(1)) ? "<" : "="); send_end(); end
    endcase
    // a halted scanner yields nothing for these
    send_text("LET q\n");
    send_end();

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("basic_token_scanner: match");
    end else begin
      $display("basic_token_scanner: mismatch");
    end
    $finish;
  end
endmodule
